### src/kbs_pkg.sv
`default_nettype none
package kbs_pkg;

    localparam int SPEED_W = 22;
    localparam int RATE_W = 18;
    localparam int WB_W = 24;
    localparam int DT_W = 16;
    localparam int POS_W = 32;
    localparam int STEER_W = 17;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 120;
    localparam int CFG_IDX_W = 2;

    localparam int CW = 34;
    localparam int CORDIC_N = 24;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;

    localparam logic [WB_W-1:0] WB_RESET = 24'd131072;
    localparam logic [DT_W-1:0] DT_RESET = 16'd6554;

    localparam logic signed [19:0] STEER_LIM = 20'sd51472;
    localparam logic [DIV_D_W-1:0] TWO_PI_Q24 = 32'd105414357;
    localparam logic signed [28:0] TWO_PI_S = 29'sd105414357;
    localparam logic signed [28:0] PI_S = 29'sd52707179;
    localparam logic signed [28:0] HALF_PI_S = 29'sd26353589;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    function automatic logic signed [CW-1:0] cordic_atan(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0: v = 34'sd843314857;
            5'd1: v = 34'sd497837829;
            5'd2: v = 34'sd263043837;
            5'd3: v = 34'sd133525159;
            5'd4: v = 34'sd67021687;
            5'd5: v = 34'sd33543516;
            5'd6: v = 34'sd16775851;
            5'd7: v = 34'sd8388437;
            5'd8: v = 34'sd4194283;
            5'd9: v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### src/kinematic_bicycle_step.sv
`default_nettype none
// One explicit Euler step of a kinematic bicycle per input word: the block keeps x, y, yaw and
// steering angle, and each word (speed, steering rate) advances them once and yields the new
// state as one output word. Wheelbase and time step must be written on the cfg port only while
// idle; the block itself does not enforce this. Each item runs on shared serial units: a
// one-bit-per-cycle multiplier (used five times), a restoring divider (for tan and for the yaw
// change, skipped with zero wheelbase), a 24-step CORDIC (used twice) and five compare and
// subtract steps for the yaw reduction mod two pi. A new word is taken once
// the previous result has been moved into the output register; a result that waits there
// holds the next item in its last step.
module kinematic_bicycle_step (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // speed [21:0], steer_rate [39:22]
    input  wire logic [kbs_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pos_x [31:0], pos_y [63:32], heading [95:64], steer_angle [112:96], zero fill
    output logic [kbs_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [kbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kbs_pkg::WB_W-1:0]           cfg_wdata
);
    import kbs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL_RATE = 4'd1;
    localparam logic [3:0] S_MUL_VD = 4'd2;
    localparam logic [3:0] S_COR_STEER = 4'd3;
    localparam logic [3:0] S_DIV_TAN = 4'd4;
    localparam logic [3:0] S_MUL_NUM = 4'd5;
    localparam logic [3:0] S_DIV_YAW = 4'd6;
    localparam logic [3:0] S_MOD_YAW = 4'd7;
    localparam logic [3:0] S_COR_YAW = 4'd8;
    localparam logic [3:0] S_MUL_X = 4'd9;
    localparam logic [3:0] S_MUL_Y = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;

    logic [3:0] state_reg;
    logic [WB_W-1:0] wb_reg;
    logic [DT_W-1:0] dt_reg;
    logic signed [POS_W-1:0] cur_x_reg, cur_y_reg, cur_yaw_reg;
    logic signed [STEER_W-1:0] cur_steer_reg, steer_new_reg;
    logic signed [SPEED_W-1:0] spd_reg;
    logic signed [38:0] vd_reg;
    logic signed [25:0] s24_reg;
    logic signed [23:0] dx_reg;
    logic signed [63:0] dyaw_reg;
    logic neg_reg, fold_reg;

    logic signed [63:0] mul_a_reg, mul_acc_reg;
    logic [25:0] mul_b_reg;
    logic [4:0] mul_cnt_reg;
    logic mul_busy_reg, mul_done_reg;
    logic signed [63:0] mul_term;

    logic cor_start_reg, cor_done;
    logic signed [CW-1:0] cor_z_reg, cor_cos, cor_sin;
    logic div_start_reg, div_done;
    logic [DIV_N_W-1:0] div_n_reg, div_q;
    logic [DIV_D_W-1:0] div_d_reg;

    logic [2:0] mod_cnt_reg;
    logic [32:0] mod_reg, mod_dvs;

    logic m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    kbs_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start_reg), .z_in(cor_z_reg),
        .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin)
    );

    kbs_divider u_divider (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg), .dividend(div_n_reg),
        .divisor(div_d_reg), .done(div_done), .quotient(div_q)
    );

    // serial multiplier term, top bit of b carries negative weight
    always_comb begin
        if (!mul_b_reg[mul_cnt_reg])
            mul_term = '0;
        else if (mul_cnt_reg == 5'd25)
            mul_term = -mul_a_reg;
        else
            mul_term = mul_a_reg;
    end

    // steering update
    logic signed [35:0] rd_sum;
    logic signed [19:0] st_sum, st_clamp;
    assign rd_sum = $signed(mul_acc_reg[35:0]) + 36'sd32768;
    assign st_sum = {{3{cur_steer_reg[STEER_W-1]}}, cur_steer_reg} + rd_sum[35:16];
    always_comb begin
        if (st_sum > STEER_LIM)
            st_clamp = STEER_LIM;
        else if (st_sum < -STEER_LIM)
            st_clamp = -STEER_LIM;
        else
            st_clamp = st_sum;
    end

    // tan division operands
    logic cos_pos;
    logic signed [CW-1:0] sin_abs;
    assign cos_pos = !cor_cos[CW-1] && (cor_cos != '0);
    assign sin_abs = cor_sin[CW-1] ? -cor_sin : cor_sin;

    logic [63:0] num_abs, q_signed;
    assign num_abs = mul_acc_reg[63] ? 64'(-mul_acc_reg) : 64'(mul_acc_reg);
    assign q_signed = neg_reg ? -div_q : div_q;

    // yaw reduction
    logic signed [32:0] yaw_ext, yaw_mag;
    logic signed [28:0] r0, r1, r2;
    logic fold;
    assign yaw_ext = {cur_yaw_reg[POS_W-1], cur_yaw_reg};
    assign yaw_mag = yaw_ext[32] ? -yaw_ext : yaw_ext;
    // two pi scaled by 16, 8, 4, 2, 1 over the five steps
    assign mod_dvs = {1'b0, TWO_PI_Q24} << (mod_cnt_reg - 3'd1);
    always_comb begin
        if (cur_yaw_reg[POS_W-1] && mod_reg != '0)
            r0 = TWO_PI_S - $signed({1'b0, mod_reg[27:0]});
        else
            r0 = $signed({1'b0, mod_reg[27:0]});
        r1 = (r0 >= PI_S) ? r0 - TWO_PI_S : r0;
        fold = 1'b0;
        r2 = r1;
        if (r1 > HALF_PI_S) begin
            r2 = r1 - PI_S;
            fold = 1'b1;
        end else if (r1 < -HALF_PI_S) begin
            r2 = r1 + PI_S;
            fold = 1'b1;
        end
    end

    // rounded Q.24 cos and sin
    logic signed [CW-1:0] cn, sn, c_rnd, s_rnd;
    assign cn = fold_reg ? -cor_cos : cor_cos;
    assign sn = fold_reg ? -cor_sin : cor_sin;
    assign c_rnd = cn + 34'sd32;
    assign s_rnd = sn + 34'sd32;

    logic signed [63:0] xy_rnd;
    assign xy_rnd = mul_acc_reg + 64'sh0000_0080_0000_0000;

    // state update with saturation
    logic signed [32:0] x_sum, y_sum;
    logic signed [63:0] yaw_sum;
    logic signed [POS_W-1:0] x_sat, y_sat, yaw_sat;
    assign x_sum = {cur_x_reg[POS_W-1], cur_x_reg} + {{9{dx_reg[23]}}, dx_reg};
    assign y_sum = {cur_y_reg[POS_W-1], cur_y_reg} + {{9{xy_rnd[63]}}, xy_rnd[63:40]};
    assign yaw_sum = {{32{cur_yaw_reg[POS_W-1]}}, cur_yaw_reg} + dyaw_reg;
    always_comb begin
        if (x_sum[32] != x_sum[31])
            x_sat = x_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            x_sat = x_sum[31:0];
        if (y_sum[32] != y_sum[31])
            y_sat = y_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            y_sat = y_sum[31:0];
        if (yaw_sum > 64'sh0000_0000_7fff_ffff)
            yaw_sat = 32'sh7fff_ffff;
        else if (yaw_sum < -64'sh0000_0000_8000_0000)
            yaw_sat = 32'sh8000_0000;
        else
            yaw_sat = yaw_sum[31:0];
    end

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wb_reg <= WB_RESET;
            dt_reg <= DT_RESET;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_yaw_reg <= '0;
            cur_steer_reg <= '0;
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg <= '0;
            cor_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cor_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid) begin
                if (cfg_index == REG_WHEELBASE)
                    wb_reg <= cfg_wdata;
                else if (cfg_index == REG_TIME_STEP)
                    dt_reg <= cfg_wdata[DT_W-1:0];
            end

            if (mul_busy_reg) begin
                mul_acc_reg <= mul_acc_reg + mul_term;
                mul_a_reg <= mul_a_reg <<< 1;
                mul_cnt_reg <= mul_cnt_reg + 5'd1;
                if (mul_cnt_reg == 5'd25) begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        spd_reg <= $signed(s_tdata[SPEED_W-1:0]);
                        mul_a_reg <= 64'($signed(s_tdata[SPEED_W+RATE_W-1:SPEED_W]));
                        mul_b_reg <= {10'd0, dt_reg};
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        mul_busy_reg <= 1'b1;
                        state_reg <= S_MUL_RATE;
                    end
                end
                S_MUL_RATE: begin
                    if (mul_done_reg) begin
                        steer_new_reg <= st_clamp[STEER_W-1:0];
                        mul_a_reg <= 64'(spd_reg);
                        mul_b_reg <= {10'd0, dt_reg};
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        mul_busy_reg <= 1'b1;
                        state_reg <= S_MUL_VD;
                    end
                end
                S_MUL_VD: begin
                    if (mul_done_reg) begin
                        vd_reg <= mul_acc_reg[38:0];
                        cor_z_reg <= {{3{cur_steer_reg[STEER_W-1]}}, cur_steer_reg, 14'd0};
                        cor_start_reg <= 1'b1;
                        state_reg <= S_COR_STEER;
                    end
                end
                S_COR_STEER: begin
                    if (cor_done) begin
                        if (cos_pos) begin
                            neg_reg <= cor_sin[CW-1];
                            div_n_reg <= {14'd0, sin_abs[CW-1:0], 16'd0};
                            div_d_reg <= cor_cos[DIV_D_W-1:0];
                            div_start_reg <= 1'b1;
                            state_reg <= S_DIV_TAN;
                        end else begin
                            mul_a_reg <= 64'(vd_reg);
                            mul_b_reg <= '0;
                            mul_acc_reg <= '0;
                            mul_cnt_reg <= '0;
                            mul_busy_reg <= 1'b1;
                            state_reg <= S_MUL_NUM;
                        end
                    end
                end
                S_DIV_TAN: begin
                    if (div_done) begin
                        mul_a_reg <= 64'(vd_reg);
                        mul_b_reg <= q_signed[25:0];
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        mul_busy_reg <= 1'b1;
                        state_reg <= S_MUL_NUM;
                    end
                end
                S_MUL_NUM: begin
                    if (mul_done_reg) begin
                        if (wb_reg == '0) begin
                            dyaw_reg <= '0;
                            mod_reg <= yaw_mag[32:0];
                            mod_cnt_reg <= 3'd5;
                            state_reg <= S_MOD_YAW;
                        end else begin
                            neg_reg <= mul_acc_reg[63];
                            div_n_reg <= num_abs;
                            div_d_reg <= {wb_reg, 8'd0};
                            div_start_reg <= 1'b1;
                            state_reg <= S_DIV_YAW;
                        end
                    end
                end
                S_DIV_YAW: begin
                    if (div_done) begin
                        dyaw_reg <= $signed(q_signed);
                        mod_reg <= yaw_mag[32:0];
                        mod_cnt_reg <= 3'd5;
                        state_reg <= S_MOD_YAW;
                    end
                end
                S_MOD_YAW: begin
                    if (mod_cnt_reg != '0) begin
                        if (mod_reg >= mod_dvs)
                            mod_reg <= mod_reg - mod_dvs;
                        mod_cnt_reg <= mod_cnt_reg - 3'd1;
                    end else begin
                        fold_reg <= fold;
                        cor_z_reg <= {{5{r2[28]}}, r2[28:0]} <<< 6;
                        cor_start_reg <= 1'b1;
                        state_reg <= S_COR_YAW;
                    end
                end
                S_COR_YAW: begin
                    if (cor_done) begin
                        s24_reg <= s_rnd[31:6];
                        mul_a_reg <= 64'(vd_reg);
                        mul_b_reg <= c_rnd[31:6];
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        mul_busy_reg <= 1'b1;
                        state_reg <= S_MUL_X;
                    end
                end
                S_MUL_X: begin
                    if (mul_done_reg) begin
                        dx_reg <= xy_rnd[63:40];
                        mul_a_reg <= 64'(vd_reg);
                        mul_b_reg <= s24_reg;
                        mul_acc_reg <= '0;
                        mul_cnt_reg <= '0;
                        mul_busy_reg <= 1'b1;
                        state_reg <= S_MUL_Y;
                    end
                end
                S_MUL_Y: begin
                    if (mul_done_reg) begin
                        cur_y_reg <= y_sat;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        cur_x_reg <= x_sat;
                        cur_yaw_reg <= yaw_sat;
                        cur_steer_reg <= steer_new_reg;
                        m_tdata_reg <= {7'd0, steer_new_reg, yaw_sat, cur_y_reg, x_sat};
                        m_tvalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    a_idle_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mul_busy_reg)
        else $error("multiplier busy while idle");
    a_steer_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_steer_reg <= STEER_LIM[STEER_W-1:0] || cur_steer_reg[STEER_W-1])
        && (cur_steer_reg >= -STEER_LIM[STEER_W-1:0] || !cur_steer_reg[STEER_W-1]))
        else $error("steering state out of range");
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV_TAN || state_reg == S_DIV_YAW))
        else $error("divider result outside a divide step");
    a_cor_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> (state_reg == S_COR_STEER || state_reg == S_COR_YAW))
        else $error("cordic result outside a cordic step");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not loaded");

endmodule
`default_nettype wire

### src/kbs_cordic.sv
`default_nettype none
module kbs_cordic (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic signed [kbs_pkg::CW-1:0] z_in,
    output logic                               done,
    output logic signed [kbs_pkg::CW-1:0]      cos_out,
    output logic signed [kbs_pkg::CW-1:0]      sin_out
);
    import kbs_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [4:0] it_reg;
    logic busy_reg, done_reg;
    logic signed [CW-1:0] dx, dy, at;

    assign dx = y_reg >>> it_reg;
    assign dy = x_reg >>> it_reg;
    assign at = cordic_atan(it_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg <= CORDIC_K;
                y_reg <= '0;
                z_reg <= z_in;
                it_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!z_reg[CW-1]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                it_reg <= it_reg + 5'd1;
                if (it_reg == 5'(CORDIC_N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule
`default_nettype wire

### src/kbs_divider.sv
`default_nettype none
module kbs_divider (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [kbs_pkg::DIV_N_W-1:0]     dividend,
    input  wire logic [kbs_pkg::DIV_D_W-1:0]     divisor,
    output logic                                 done,
    output logic [kbs_pkg::DIV_N_W-1:0]          quotient
);
    import kbs_pkg::*;

    logic [DIV_N_W-1:0] num_reg, q_reg;
    logic [DIV_D_W-1:0] den_reg, rem_reg;
    logic [5:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [DIV_D_W:0] sh, diff;
    logic ge;

    assign sh = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff = sh - {1'b0, den_reg};
    assign ge = sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= dividend;
                den_reg <= divisor;
                rem_reg <= '0;
                q_reg <= '0;
                cnt_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
                q_reg <= {q_reg[DIV_N_W-2:0], ge};
                num_reg <= {num_reg[DIV_N_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire
